@@ hdl/pol_pkg.sv @@
// Shared types and constants for the positional ordered list core.
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int OUTIDX_W = 7;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DISPLAY   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Kind of work that the cell row does
  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_INS  = 2'd1,
    CK_DEL  = 2'd2,
    CK_ROT  = 2'd3
  } chain_kind_t;

  typedef struct packed {
    chain_kind_t            kind;
    logic [IDX_W-1:0]       pos;
    logic signed [VAL_W-1:0] value;
  } chain_cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_EXEC = 2'd1,
    FS_DISP = 2'd2
  } fsm_state_t;

endpackage

@@ hdl/pol_cell.sv @@
// One storage cell of the list row: holds one element and trades it with its neighbors.
module pol_cell (
  input  logic                           clk,
  input  logic [pol_pkg::IDX_W-1:0]      idx,
  input  pol_pkg::chain_cmd_t            cmd,
  input  logic signed [pol_pkg::VAL_W-1:0] left,
  input  logic signed [pol_pkg::VAL_W-1:0] right,
  output logic signed [pol_pkg::VAL_W-1:0] data,
  output logic signed [pol_pkg::VAL_W-1:0] taken
);
  import pol_pkg::*;

  logic signed [VAL_W-1:0] data_next;

  // Pick the new content from the row command and this cell's place
  always_comb begin
    data_next = data;
    case (cmd.kind)
      CK_INS: begin
        if (idx == cmd.pos) begin
          data_next = cmd.value;
        end else if (idx > cmd.pos) begin
          data_next = left;
        end
      end
      CK_DEL: begin
        if (idx >= cmd.pos) begin
          data_next = right;
        end
      end
      CK_ROT: begin
        if (idx == cmd.pos) begin
          data_next = cmd.value;
        end else if (idx < cmd.pos) begin
          data_next = right;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Offer the element that a delete removes
  assign taken = (cmd.kind == CK_DEL && idx == cmd.pos) ? data : '0;

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ hdl/pol_chain.sv @@
// Row of list cells with the head tap and the removed-element collector.
module pol_chain (
  input  logic                             clk,
  input  pol_pkg::chain_cmd_t              cmd,
  output logic signed [pol_pkg::VAL_W-1:0] head,
  output logic signed [pol_pkg::VAL_W-1:0] taken
);
  import pol_pkg::*;

  logic signed [VAL_W-1:0] data  [CAPACITY];
  logic signed [VAL_W-1:0] taken_w [CAPACITY];

  // Build the row; the ends see zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_w;
    logic signed [VAL_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = data[i+1];
    end
    pol_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(i)),
      .cmd   (cmd),
      .left  (left_w),
      .right (right_w),
      .data  (data[i]),
      .taken (taken_w[i])
    );
  end

  assign head = data[0];

  // Merge the removed element; at most one cell drives a nonzero word
  always_comb begin
    taken = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taken = taken | taken_w[i];
    end
  end

endmodule

@@ hdl/positional_ordered_list_core.sv @@
// Positional ordered list core: one request per transaction, results through an output register.
//
// A bounded ordered list of signed 32-bit values held in a row of CAPACITY cells.
// A request is taken only when the core is idle. Inserts and deletes register the request,
// then shift the whole cell row once the output register is free, and give one
// result. A display rotates the row one place per cycle, unless the output stalls,
// and gives one result per element; the last result of every request has last set.
// Error results carry value_out and index_out of zero and leave the list unchanged.
// Op code 7 is dropped with no result.
module positional_ordered_list_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       op,
  input  logic signed [pol_pkg::VAL_W-1:0] value,
  input  logic [pol_pkg::POS_W-1:0]        position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic signed [pol_pkg::VAL_W-1:0] value_out,
  output logic [pol_pkg::OUTIDX_W-1:0]     index_out,
  output logic                             last
);
  import pol_pkg::*;

  fsm_state_t state, state_next;

  logic [2:0]              req_op;
  logic signed [VAL_W-1:0] req_value;
  logic [POS_W-1:0]        req_pos;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] disp_idx;
  logic [CNT_W-1:0] disp_idx_next;

  chain_cmd_t              cmd;
  logic signed [VAL_W-1:0] head;
  logic signed [VAL_W-1:0] taken;

  logic                    out_free;
  logic                    res_load;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_value;
  logic [OUTIDX_W-1:0]     res_index;
  logic                    res_last;
  logic                    disp_start;
  logic                    disp_end;

  logic [POS_W:0] ipos;
  logic [POS_W:0] dpos;
  logic [POS_W:0] cnt_ext;

  pol_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .head  (head),
    .taken (taken)
  );

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != FS_IDLE);
  assign cnt_ext  = (POS_W + 1)'(count);

  // Resolve the target position of insert and delete requests
  always_comb begin
    case (req_op)
      OP_INS_FRONT: ipos = (POS_W + 1)'(1);
      OP_INS_END:   ipos = cnt_ext + (POS_W + 1)'(1);
      default:      ipos = {1'b0, req_pos};
    endcase
    case (req_op)
      OP_DEL_FRONT: dpos = (POS_W + 1)'(1);
      OP_DEL_END:   dpos = cnt_ext;
      default:      dpos = {1'b0, req_pos};
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (in_valid) begin
          state_next = FS_EXEC;
        end
      end
      FS_EXEC: begin
        if (disp_start) begin
          state_next = FS_DISP;
        end else if (out_free) begin
          state_next = FS_IDLE;
        end
      end
      FS_DISP: begin
        if (disp_end) begin
          state_next = FS_IDLE;
        end
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

  // Row command, count update and result of the current cycle
  always_comb begin
    cmd           = '{kind: CK_NONE, pos: '0, value: req_value};
    count_next    = count;
    disp_idx_next = disp_idx;
    res_load      = 1'b0;
    res_status    = ST_OK;
    res_value     = '0;
    res_index     = '0;
    res_last      = 1'b1;
    disp_start    = 1'b0;
    disp_end      = 1'b0;
    case (state)
      FS_EXEC: begin
        if (out_free) begin
          case (req_op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
              res_load = 1'b1;
              if (count == CNT_W'(CAPACITY)) begin
                res_status = ST_FULL;
              end else if (ipos == '0 || ipos > cnt_ext + (POS_W + 1)'(1)) begin
                res_status = ST_BOUNDS;
              end else begin
                cmd.kind   = CK_INS;
                cmd.pos    = IDX_W'(ipos - (POS_W + 1)'(1));
                count_next = count + CNT_W'(1);
                res_value  = req_value;
                res_index  = OUTIDX_W'(ipos);
              end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
              res_load = 1'b1;
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else if (dpos == '0 || dpos > cnt_ext) begin
                res_status = ST_BOUNDS;
              end else begin
                cmd.kind   = CK_DEL;
                cmd.pos    = IDX_W'(dpos - (POS_W + 1)'(1));
                count_next = count - CNT_W'(1);
                res_value  = taken;
                res_index  = OUTIDX_W'(dpos);
              end
            end
            OP_DISPLAY: begin
              if (count == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                disp_start    = 1'b1;
                disp_idx_next = '0;
              end
            end
            default: begin
              res_load = 1'b0;
            end
          endcase
        end
      end
      FS_DISP: begin
        if (out_free) begin
          // Emit the head and rotate it behind the last element
          cmd.kind      = CK_ROT;
          cmd.pos       = IDX_W'(count - CNT_W'(1));
          cmd.value     = head;
          res_load      = 1'b1;
          res_value     = head;
          res_index     = OUTIDX_W'(disp_idx + CNT_W'(1));
          res_last      = (disp_idx + CNT_W'(1) == count);
          disp_end      = res_last;
          disp_idx_next = disp_idx + CNT_W'(1);
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_IDLE;
      count     <= '0;
      disp_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      disp_idx  <= disp_idx_next;
      out_valid <= res_load || (out_valid && out_stall);
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op    <= op;
      req_value <= value;
      req_pos   <= position;
    end
    if (res_load) begin
      status    <= res_status;
      value_out <= res_value;
      index_out <= res_index;
      last      <= res_last;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result without last");

  a_disp_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == FS_DISP |-> count != '0)
    else $error("display streaming over an empty list");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.kind == CK_INS |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_rot_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.kind == CK_ROT |=> $stable(count))
    else $error("display changed the element count");

endmodule
